// ===== rtl/core/multi_crc16_collision_check_top_macros.svh =====
// Assertion helpers for the CRC-16 collision checker.
`ifndef MULTI_CRC16_COLLISION_CHECK_TOP_MACROS_SVH
`define MULTI_CRC16_COLLISION_CHECK_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MCRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define MCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mcrc_pkg.sv =====
package mcrc_pkg;

  localparam int unsigned NumChan     = 4;
  localparam int unsigned DefCrcCount = 4;
  localparam int unsigned CrcW        = 16;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned ChanW       = 2;
  localparam int unsigned CfgIdxW     = 3;

  localparam logic [CrcW-1:0] PolyRst [NumChan] = '{16'h1021, 16'h8005, 16'h1021, 16'h8005};
  localparam logic [CrcW-1:0] InitRst [NumChan] = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};

  typedef enum logic [CfgIdxW-1:0] {
    REG_POLY_0 = 3'd0,
    REG_POLY_1 = 3'd1,
    REG_POLY_2 = 3'd2,
    REG_POLY_3 = 3'd3,
    REG_INIT_0 = 3'd4,
    REG_INIT_1 = 3'd5,
    REG_INIT_2 = 3'd6,
    REG_INIT_3 = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic             mode;
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } req_t;

  typedef struct packed {
    logic [ChanW-1:0] channel_index;
    logic [CrcW-1:0]  crc_value;
    logic             matches_reference;
    logic             last_result;
  } res_t;

  // Per-byte control shared by all lanes.
  typedef struct packed {
    logic adv;    // consume one byte this cycle
    logic start;  // first byte of a block: seed from init
  } lane_ctrl_t;

endpackage

// ===== rtl/core/mcrc_lane.sv =====
module mcrc_lane (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mcrc_pkg::lane_ctrl_t           ctrl_i,
  input  logic [mcrc_pkg::CrcW-1:0]      poly_i,
  input  logic [mcrc_pkg::CrcW-1:0]      init_i,
  input  logic [mcrc_pkg::ByteW-1:0]     data_i,
  output logic [mcrc_pkg::CrcW-1:0]      crc_o
);

  logic [mcrc_pkg::CrcW-1:0] rem_q, rem_d;

  // One byte of MSB-first division, eight shift steps.
  always_comb begin
    logic [mcrc_pkg::CrcW-1:0] r;
    r = ctrl_i.start ? init_i : rem_q;
    r = r ^ {data_i, {(mcrc_pkg::CrcW - mcrc_pkg::ByteW){1'b0}}};
    for (int k = 0; k < mcrc_pkg::ByteW; k++) begin
      if (r[mcrc_pkg::CrcW-1]) begin
        r = {r[mcrc_pkg::CrcW-2:0], 1'b0} ^ poly_i;
      end else begin
        r = {r[mcrc_pkg::CrcW-2:0], 1'b0};
      end
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (ctrl_i.adv) begin
      rem_q <= rem_d;
    end
  end

  assign crc_o = rem_d;

endmodule

// ===== rtl/core/multi_crc16_collision_check_top.sv =====
// Multi-channel CRC-16 collision checker.
// Input channel: in_valid_i / in_stall_o carry one request per byte (mode, data_byte,
// last_byte). Bytes are grouped into blocks closed by last_byte; every channel runs an
// MSB-first CRC-16 with its own polynomial and seed, no reflection, no final xor.
// Output channel: out_valid_o / out_stall_i carry CrcCount results per block, channel 0
// first, last_result set on the final one. A reference block (mode 0) stores the CRCs
// as golden values; a test block (mode 1) flags channels whose CRC hits the golden value.
// Flow: a byte is taken into the input register and advances the remainders from there;
// a closing byte then loads the result buffer, which offers the first result of the block.
// Throughput: one byte per cycle while no closing byte stalls, set by the combinational
// byte step in each lane. A closing byte fills the result buffer, which drains one result
// per cycle while the receiver does not stall.
// Stall: only a closing byte waits, and only while the previous block's results are
// still draining; ordinary bytes keep flowing. A stalled result holds its payload.
// Reset: polynomials and seeds return to their defaults, golden values clear to zero,
// the next byte opens a new block. Write the configuration only while no request is in flight.
module multi_crc16_collision_check_top #(
  parameter int unsigned CrcCount = mcrc_pkg::DefCrcCount
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mcrc_pkg::req_t                in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mcrc_pkg::res_t                out_res_o,
  input  logic                          cfg_we_i,
  input  logic [mcrc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mcrc_pkg::CrcW-1:0]     cfg_wdata_i
);

  localparam logic [mcrc_pkg::ChanW-1:0] LastIdx = mcrc_pkg::ChanW'(CrcCount - 1);

  // Configuration registers: all four channels stay writable.
  logic [mcrc_pkg::CrcW-1:0] poly_q [mcrc_pkg::NumChan];
  logic [mcrc_pkg::CrcW-1:0] init_q [mcrc_pkg::NumChan];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= mcrc_pkg::PolyRst;
      init_q <= mcrc_pkg::InitRst;
    end else if (cfg_we_i) begin
      unique case (mcrc_pkg::cfg_reg_e'(cfg_idx_i))
        mcrc_pkg::REG_POLY_0: poly_q[0] <= cfg_wdata_i;
        mcrc_pkg::REG_POLY_1: poly_q[1] <= cfg_wdata_i;
        mcrc_pkg::REG_POLY_2: poly_q[2] <= cfg_wdata_i;
        mcrc_pkg::REG_POLY_3: poly_q[3] <= cfg_wdata_i;
        mcrc_pkg::REG_INIT_0: init_q[0] <= cfg_wdata_i;
        mcrc_pkg::REG_INIT_1: init_q[1] <= cfg_wdata_i;
        mcrc_pkg::REG_INIT_2: init_q[2] <= cfg_wdata_i;
        mcrc_pkg::REG_INIT_3: init_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register.
  logic           in_vld_q;
  mcrc_pkg::req_t in_q;
  logic           adv;
  logic           buf_free;
  logic           out_acc;

  logic                       out_vld_q;
  logic [mcrc_pkg::ChanW-1:0] idx_q;

  assign out_acc  = out_vld_q && !out_stall_i;
  // Buffer is free now, or frees at this edge as its final result leaves.
  assign buf_free = !out_vld_q || (out_acc && (idx_q == LastIdx));
  assign adv      = in_vld_q && (!in_q.last_byte || buf_free);
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_req_i;
    end
  end

  // Block start: set at reset and after each closing byte.
  logic start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
    end else if (adv) begin
      start_q <= in_q.last_byte;
    end
  end

  mcrc_pkg::lane_ctrl_t lane_ctrl;
  assign lane_ctrl.adv   = adv;
  assign lane_ctrl.start = start_q;

  logic [mcrc_pkg::CrcW-1:0] lane_crc [CrcCount];

  for (genvar g = 0; g < CrcCount; g++) begin : g_lane
    mcrc_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl),
      .poly_i (poly_q[g]),
      .init_i (init_q[g]),
      .data_i (in_q.data_byte),
      .crc_o  (lane_crc[g])
    );
  end

  // Result buffer and golden values.
  logic                      load;
  logic                      buf_mode_q;
  logic [mcrc_pkg::CrcW-1:0] buf_crc_q [mcrc_pkg::NumChan];
  logic [mcrc_pkg::CrcW-1:0] golden_q  [mcrc_pkg::NumChan];

  assign load = adv && in_q.last_byte;

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_mode_q <= in_q.mode;
      for (int i = 0; i < CrcCount; i++) begin
        buf_crc_q[i] <= lane_crc[i];
      end
    end
  end

  // Golden values change only on a reference block, so a test block's results can be
  // compared as they leave.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      golden_q <= '{default: '0};
    end else if (load && !in_q.mode) begin
      for (int i = 0; i < CrcCount; i++) begin
        golden_q[i] <= lane_crc[i];
      end
    end
  end

  // Drain control: reload on a closing byte, advance on each taken result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (load) begin
      out_vld_q <= 1'b1;
      idx_q     <= '0;
    end else if (out_acc) begin
      if (idx_q == LastIdx) begin
        out_vld_q <= 1'b0;
        idx_q     <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign out_valid_o                 = out_vld_q;
  assign out_res_o.channel_index     = idx_q;
  assign out_res_o.crc_value         = buf_crc_q[idx_q];
  assign out_res_o.matches_reference = buf_mode_q && (buf_crc_q[idx_q] == golden_q[idx_q]);
  assign out_res_o.last_result       = (idx_q == LastIdx);

`include "multi_crc16_collision_check_top_macros.svh"

  // Only a closing byte may wait, and only behind a busy result buffer.
  `MCRC_ASSERT_NOW(a_stall_cause, in_stall_o, in_q.last_byte && out_vld_q, "bad input stall")
  // A closing byte that advances opens a fresh drain at channel zero.
  `MCRC_ASSERT_NEXT(a_load_start, load, out_vld_q && (idx_q == '0), "drain not restarted")
  // A taken result that is not the final one is followed by the next channel.
  `MCRC_ASSERT_NEXT(a_drain_cont, out_acc && (idx_q != LastIdx),
                    out_vld_q && (idx_q == $past(idx_q) + 1'b1), "drain broken")

endmodule

// ===== verif/tb_multi_crc16_collision_check_top.sv =====
module tb_multi_crc16_collision_check_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mcrc_pkg::*;

  // Request mode codes: a reference block stores golden CRCs, a test block compares.
  localparam logic MODE_REF  = 1'b0;
  localparam logic MODE_TEST = 1'b1;
  localparam int unsigned LANES = DefCrcCount;
  // Cycles to let pass after the last result before touching the registers.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned ITEMS_PER_SETTING = 38;

  typedef logic [ByteW-1:0] byte_q_t [$];

  // Predicts every channel result from the accepted byte stream and the register
  // writes, and holds the results still awaited from the block.
  class crc_collision_board;
    logic [CrcW-1:0] poly [LANES];
    logic [CrcW-1:0] seed [LANES];
    logic [CrcW-1:0] remainder [LANES];
    logic [CrcW-1:0] golden [LANES];
    bit              opening;
    res_t            awaited [$];
    int unsigned     errors, requests, results, hits;

    function new();
      for (int i = 0; i < LANES; i++) begin
        poly[i]      = PolyRst[i];
        seed[i]      = InitRst[i];
        remainder[i] = '0;
        golden[i]    = '0;
      end
      opening = 1'b1;
    endfunction

    // One byte of MSB-first polynomial division, x^16 term implied.
    function automatic logic [CrcW-1:0] divide_byte(logic [CrcW-1:0] rem,
                                                    logic [CrcW-1:0] gen,
                                                    logic [ByteW-1:0] data);
      logic [CrcW-1:0] r;
      r = rem ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) r = r[CrcW-1] ? ((r << 1) ^ gen) : (r << 1);
      return r;
    endfunction

    function void write_reg(cfg_reg_e r, logic [CrcW-1:0] v);
      if (r < REG_INIT_0) poly[r] = v;
      else seed[r - REG_INIT_0] = v;
    endfunction

    function void note_request(req_t req);
      res_t want;
      requests++;
      for (int i = 0; i < LANES; i++)
        remainder[i] = divide_byte(opening ? seed[i] : remainder[i], poly[i], req.data_byte);
      opening = 1'b0;
      if (!req.last_byte) return;
      // Only the mode of the closing byte decides store or compare.
      for (int i = 0; i < LANES; i++) begin
        want.channel_index     = ChanW'(i);
        want.crc_value         = remainder[i];
        want.matches_reference = (req.mode == MODE_TEST) && (remainder[i] == golden[i]);
        want.last_result       = (i == LANES - 1);
        if (req.mode == MODE_REF) golden[i] = remainder[i];
        awaited.push_back(want);
      end
      opening = 1'b1;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      results++;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result chan %0d crc %h", got.channel_index, got.crc_value));
        return;
      end
      want = awaited.pop_front();
      if (want.matches_reference) hits++;
      if (got.channel_index !== want.channel_index)
        report($sformatf("channel_index %0d, want %0d", got.channel_index, want.channel_index));
      if (got.crc_value !== want.crc_value)
        report($sformatf("chan %0d crc_value %h, want %h", want.channel_index,
                         got.crc_value, want.crc_value));
      if (got.matches_reference !== want.matches_reference)
        report($sformatf("chan %0d matches_reference %b, want %b", want.channel_index,
                         got.matches_reference, want.matches_reference));
      if (got.last_result !== want.last_result)
        report($sformatf("chan %0d last_result %b, want %b", want.channel_index,
                         got.last_result, want.last_result));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  req_t                 in_req_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  res_t                 out_res_o;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CrcW-1:0]      cfg_wdata_i;

  crc_collision_board collisions = new();
  byte_q_t            golden_bytes;   // bytes of the latest reference block, for replays
  int unsigned        send_idle_pct, recv_idle_pct;
  int unsigned        sent, blocks;

  multi_crc16_collision_check_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: stall at random, changing only on the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check every result taken by the receiver against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) collisions.check_result(out_res_o);
  end

  // Offer one byte request; return at the falling edge after it was taken, with valid
  // still high so that back-to-back requests need no extra assignment.
  task automatic send_byte(input logic mode, input logic [ByteW-1:0] data, input logic last);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{mode: mode, data_byte: data, last_byte: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    collisions.note_request(in_req_i);
    sent++;
    @(negedge clk_i);
  endtask

  // Send a whole block; the bytes before the closing one carry mode ^ flip, so a
  // flipped block checks that only the closing mode counts.
  task automatic send_block(input logic mode, input byte_q_t bytes, input logic flip);
    for (int i = 0; i < bytes.size(); i++) begin
      if (i == bytes.size() - 1) send_byte(mode, bytes[i], 1'b1);
      else send_byte(mode ^ flip, bytes[i], 1'b0);
    end
    if (mode == MODE_REF) golden_bytes = bytes;
    blocks++;
  endtask

  // Hold the sender off until every predicted result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (collisions.awaited.size() != 0);
  endtask

  // Drain, then let the last byte work its way through before any register write.
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Leave the write enable high; the caller drops it after the last write.
  task automatic write_reg(input cfg_reg_e r, input logic [CrcW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= v;
    collisions.write_reg(r, v);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [CrcW-1:0] polys [LANES],
                           input logic [CrcW-1:0] seeds [LANES]);
    cfg_reg_e r;
    r = r.first();
    do begin
      write_reg(r, (r < REG_INIT_0) ? polys[r] : seeds[r - REG_INIT_0]);
      r = r.next();
    end while (r != r.first());
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CrcW-1:0] pick_reg_value();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return CrcW'($urandom_range(16'hFFFF));
    endcase
  endfunction

  initial begin
    #10_000_000;
    $display("tb_multi_crc16_collision_check_top: errors");
    $finish;
  end

  initial begin
    logic [CrcW-1:0] rnd_poly [LANES];
    logic [CrcW-1:0] rnd_seed [LANES];
    byte_q_t         bytes;
    int unsigned     goal, len;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_req_i      = '0;
    out_stall_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_POLY_0;
    cfg_wdata_i   = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sent          = 0;
    blocks        = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: a test block before any reference compares against zero golden values.
    send_block(MODE_TEST, '{8'h00}, 1'b0);
    // Store, then replay the same bytes: every channel must report a collision.
    // Both blocks carry the other mode on their leading bytes.
    send_block(MODE_REF, '{8'hFF, 8'h00, 8'h80}, 1'b1);
    send_block(MODE_TEST, '{8'hFF, 8'h00, 8'h80}, 1'b1);
    send_block(MODE_TEST, '{8'h01}, 1'b0);

    // Extreme polynomials and seeds.
    settle();
    configure('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF},
              '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000});
    send_block(MODE_REF, '{8'h00}, 1'b0);
    send_block(MODE_TEST, '{8'hFF}, 1'b0);
    send_block(MODE_REF, '{8'hFF, 8'hFF}, 1'b0);
    settle();
    configure('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000},
              '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF});
    send_block(MODE_TEST, '{8'h55, 8'hAA}, 1'b0);

    // Write mid-block: the polynomial bites on the next byte, the seed on the next block.
    send_byte(MODE_REF, 8'h12, 1'b0);
    settle();
    write_reg(REG_POLY_0, 16'h8408);
    write_reg(REG_INIT_1, 16'h1D0F);
    cfg_we_i <= 1'b0;
    send_byte(MODE_REF, 8'h34, 1'b1);
    blocks++;
    send_block(MODE_TEST, '{8'h56}, 1'b0);

    settle();
    configure(PolyRst, InitRst);
    send_block(MODE_TEST, '{8'h00}, 1'b0);

    // Random: three idling profiles, each with a few register settings.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int sub = 0; sub < 3; sub++) begin
        settle();
        for (int i = 0; i < LANES; i++) begin
          rnd_poly[i] = pick_reg_value();
          rnd_seed[i] = pick_reg_value();
        end
        configure(rnd_poly, rnd_seed);
        goal = sent + ITEMS_PER_SETTING;
        while (sent < goal) begin
          if (golden_bytes.size() != 0 && $urandom_range(2) == 0) begin
            // Replay the stored reference bytes to provoke collisions.
            send_block(MODE_TEST, golden_bytes, 1'($urandom_range(1)));
          end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
            bytes.delete();
            repeat (len) bytes.push_back(ByteW'($urandom_range(255)));
            send_block(1'($urandom_range(1)), bytes, 1'($urandom_range(1)));
          end
          // Now and then pause the sender until the result buffer is empty.
          if ($urandom_range(15) == 0) drain();
        end
      end
    end

    drain();
    repeat (10) @(posedge clk_i);

    $display("covered %0d byte requests in %0d blocks, extreme and random polynomials/seeds",
             collisions.requests, blocks);
    $display("checked %0d channel results, %0d of them golden collisions",
             collisions.results, collisions.hits);
    if (collisions.errors == 0) begin
      $display("tb_multi_crc16_collision_check_top: clean");
    end else begin
      $display("tb_multi_crc16_collision_check_top: errors");
    end
    $finish;
  end

endmodule
